// ===== rtl/core/mhpq_pkg.sv =====
// Shared types and codes for the min-heap priority queue.
`timescale 1ns / 1ps

package mhpq_pkg;

	// Request kinds
	localparam logic [1:0] KIND_INSERT  = 2'd0;
	localparam logic [1:0] KIND_EXTRACT = 2'd1;
	localparam logic [1:0] KIND_REPLACE = 2'd2;
	localparam logic [1:0] KIND_DELETE  = 2'd3;

	// Result status codes
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_FULL   = 2'd1;
	localparam logic [1:0] STAT_EMPTY  = 2'd2;
	localparam logic [1:0] STAT_BADPOS = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] key;
		logic [5:0]  position;
	} req_t;

	typedef struct packed {
		logic [31:0] taken_key;
		logic [1:0]  status;
		logic [31:0] min_key;
		logic [6:0]  count;
	} rsp_t;

endpackage

// ===== rtl/core/mhpq_ram.sv =====
// Heap key storage: one write port, two registered read ports.
`timescale 1ns / 1ps

module mhpq_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read-old on a same-cycle collision; the controller never relies on it
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== rtl/core/min_heap_priority_queue_core.sv =====
// Top level of the binary min-heap priority queue.
`timescale 1ns / 1ps
//
//  channel | signals                | direction | moves
//  --------+------------------------+-----------+-------------------------------
//  req     | req_valid, req_stall   | in        | kind, key, position
//  rsp     | rsp_valid, rsp_stall   | out       | taken_key, status, min_key, count
//
// One request at a time. A request that is rejected, fills an empty heap or
// extracts the only key goes straight to the result; any other request first
// reads the key RAM and sifts a key where needed. The sift loop does one heap
// level per cycle off the two-port key RAM (read both children or the parent,
// compare, write back).
// Reset clears the entry count and the controller; RAM contents are left as is.
// A stalled response sits in the output register while the next request runs;
// it finishes only when that register frees up.

module min_heap_priority_queue_core #(
	parameter int CAPACITY  = 64,
	parameter int KEY_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  mhpq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output mhpq_pkg::rsp_t rsp
);

	import mhpq_pkg::*;

	localparam int AW  = $clog2(CAPACITY);      // RAM address bits
	localparam int CW  = $clog2(CAPACITY + 1);  // entry count bits
	localparam int CHW = AW + 2;                // child index, holds 2*i+2
	localparam int PW  = (CW > 6) ? CW : 6;     // position compare width
	localparam int KW  = KEY_WIDTH;

	// controller states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_LOADX  = 3'd1;  // extract: last key arriving
	localparam logic [2:0] S_DEL    = 3'd2;  // delete: victim and last key arriving
	localparam logic [2:0] S_SETTLE = 3'd3;  // parent compare picks up or down
	localparam logic [2:0] S_UP     = 3'd4;
	localparam logic [2:0] S_DOWN   = 3'd5;
	localparam logic [2:0] S_PLACE  = 3'd6;  // drop moving key into the root
	localparam logic [2:0] S_RESULT = 3'd7;

	function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] i);
		logic [AW-1:0] d;
		d = i - AW'(1);
		return d >> 1;
	endfunction

	function automatic logic [CHW-1:0] left_of(input logic [AW-1:0] i);
		return {1'b0, i, 1'b1};
	endfunction

	logic [2:0]    state_q, state_n;
	logic [CW-1:0] cnt_q, cnt_n;
	logic [AW-1:0] idx_q, idx_n;        // current hole position
	logic [KW-1:0] mkey_q, mkey_n;      // key being sifted
	logic [KW-1:0] root_q, root_n;      // mirror of entry 0
	logic [KW-1:0] taken_q, taken_n;
	logic [1:0]    status_q, status_n;
	logic          rsp_valid_q, rsp_valid_n;
	rsp_t          rsp_q, rsp_n;

	logic          we;
	logic [AW-1:0] waddr, raddr_a, raddr_b;
	logic [KW-1:0] wdata, rdata_a, rdata_b;

	// request decode helpers
	logic [KW-1:0]  req_key;
	logic [PW-1:0]  pos_ext;
	logic [AW-1:0]  pos_idx;
	logic           pos_ok;
	logic [CW-1:0]  cnt_dec;
	logic [CHW-1:0] pos_lc;

	// sift helpers
	logic [AW-1:0]  par;
	logic [CHW-1:0] lc, rc, cnt_ext, child, child_lc;
	logic           take_l, take_r;
	logic [KW-1:0]  best_val;
	logic           rsp_free;

	assign req_key = KW'(req.key);
	assign pos_ext = PW'(req.position);
	assign pos_idx = pos_ext[AW-1:0];
	assign pos_ok  = pos_ext < PW'(cnt_q);
	assign cnt_dec = cnt_q - CW'(1);
	assign pos_lc  = left_of(pos_idx);

	assign par     = parent_of(idx_q);
	assign lc      = left_of(idx_q);
	assign rc      = lc + CHW'(1);
	assign cnt_ext = CHW'(cnt_q);

	// min-child pick: left unless right strictly smaller, move only if strictly below
	assign take_l   = (lc < cnt_ext) && (rdata_a < mkey_q);
	assign best_val = take_l ? rdata_a : mkey_q;
	assign take_r   = (rc < cnt_ext) && (rdata_b < best_val);
	assign child    = take_r ? rc : lc;
	assign child_lc = left_of(child[AW-1:0]);

	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_n     = state_q;
		cnt_n       = cnt_q;
		idx_n       = idx_q;
		mkey_n      = mkey_q;
		taken_n     = taken_q;
		status_n    = status_q;
		rsp_valid_n = rsp_valid_q && rsp_stall;
		rsp_n       = rsp_q;
		we          = 1'b0;
		waddr       = idx_q;
		wdata       = mkey_q;
		raddr_a     = par;
		raddr_b     = par;

		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					taken_n  = '0;
					status_n = STAT_OK;
					mkey_n   = req_key;
					idx_n    = pos_idx;
					state_n  = S_RESULT;
					if (req.kind == KIND_INSERT) begin
						if (cnt_q == CW'(CAPACITY)) begin
							status_n = STAT_FULL;
						end else begin
							cnt_n = cnt_q + CW'(1);
							idx_n = cnt_q[AW-1:0];
							if (cnt_q == '0) begin
								we    = 1'b1;
								waddr = '0;
								wdata = req_key;
							end else begin
								raddr_a = parent_of(cnt_q[AW-1:0]);
								state_n = S_UP;
							end
						end
					end else if (cnt_q == '0) begin
						status_n = STAT_EMPTY;
					end else if (req.kind == KIND_EXTRACT) begin
						taken_n = root_q;
						cnt_n   = cnt_dec;
						idx_n   = '0;
						if (cnt_dec != '0) begin
							raddr_a = cnt_dec[AW-1:0];
							state_n = S_LOADX;
						end
					end else if (!pos_ok) begin
						status_n = STAT_BADPOS;
					end else if (req.kind == KIND_REPLACE) begin
						if (pos_idx == '0) begin
							raddr_a = pos_lc[AW-1:0];
							raddr_b = AW'(pos_lc + CHW'(1));
							state_n = S_DOWN;
						end else begin
							raddr_a = parent_of(pos_idx);
							state_n = S_SETTLE;
						end
					end else begin
						cnt_n   = cnt_dec;
						raddr_a = pos_idx;
						raddr_b = cnt_dec[AW-1:0];
						state_n = S_DEL;
					end
				end
			end
			S_LOADX: begin
				mkey_n  = rdata_a;
				raddr_a = lc[AW-1:0];
				raddr_b = rc[AW-1:0];
				state_n = S_DOWN;
			end
			S_DEL: begin
				taken_n = rdata_a;
				if (CW'(idx_q) == cnt_q) begin
					// removed the last entry, nothing moves
					state_n = S_RESULT;
				end else begin
					mkey_n = rdata_b;
					if (idx_q == '0) begin
						raddr_a = lc[AW-1:0];
						raddr_b = rc[AW-1:0];
						state_n = S_DOWN;
					end else begin
						state_n = S_SETTLE;
					end
				end
			end
			S_SETTLE, S_UP: begin
				// rdata_a holds the parent of the hole
				if (rdata_a > mkey_q) begin
					we      = 1'b1;
					wdata   = rdata_a;
					idx_n   = par;
					raddr_a = parent_of(par);
					state_n = (par == '0) ? S_PLACE : S_UP;
				end else if (state_q == S_UP) begin
					we      = 1'b1;
					state_n = S_RESULT;
				end else begin
					raddr_a = lc[AW-1:0];
					raddr_b = rc[AW-1:0];
					state_n = S_DOWN;
				end
			end
			S_DOWN: begin
				we = 1'b1;
				if (take_l || take_r) begin
					wdata   = take_r ? rdata_b : rdata_a;
					idx_n   = child[AW-1:0];
					raddr_a = child_lc[AW-1:0];
					raddr_b = AW'(child_lc + CHW'(1));
				end else begin
					state_n = S_RESULT;
				end
			end
			S_PLACE: begin
				we      = 1'b1;
				state_n = S_RESULT;
			end
			S_RESULT: begin
				if (rsp_free) begin
					rsp_n.taken_key = 32'(taken_q);
					rsp_n.status    = status_q;
					rsp_n.min_key   = (cnt_q != '0) ? 32'(root_q) : 32'd0;
					rsp_n.count     = 7'(cnt_q);
					rsp_valid_n     = 1'b1;
					state_n         = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase

		root_n = (we && waddr == '0) ? wdata : root_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			cnt_q       <= cnt_n;
			rsp_valid_q <= rsp_valid_n;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_n;
		mkey_q   <= mkey_n;
		root_q   <= root_n;
		taken_q  <= taken_n;
		status_q <= status_n;
		rsp_q    <= rsp_n;
	end

	mhpq_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(KW)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== tb/min_heap_priority_queue_core_checker.sv =====
// Channel monitor, heap predictor and result comparison for the min-heap queue.
`timescale 1ns / 1ps

module min_heap_priority_queue_core_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  mhpq_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  mhpq_pkg::rsp_t rsp,
	output int             fail_count,
	output int             pending
);
	import mhpq_pkg::*;

	localparam int HEAP_DEPTH = 64;

	logic [31:0] heap_keys [0:HEAP_DEPTH-1];
	int          key_count;
	rsp_t        heap_outcomes_q [$];
	rsp_t        oldest_outcome;
	int          mismatches;

	assign fail_count = mismatches;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	function automatic void swap_keys(input int a, input int b);
		logic [31:0] t;
		t = heap_keys[a];
		heap_keys[a] = heap_keys[b];
		heap_keys[b] = t;
	endfunction

	// parent must be strictly greater before a swap, so equal keys stay put
	function automatic void bubble_up(input int i);
		int p;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (heap_keys[p] <= heap_keys[i])
				break;
			swap_keys(p, i);
			i = p;
		end
	endfunction

	// left child wins ties; swap only on a strictly smaller child
	function automatic void bubble_down(input int i);
		int l;
		int r;
		int best;
		while (1) begin
			l = 2 * i + 1;
			r = l + 1;
			best = i;
			if (l < key_count && heap_keys[l] < heap_keys[best])
				best = l;
			if (r < key_count && heap_keys[r] < heap_keys[best])
				best = r;
			if (best == i)
				break;
			swap_keys(i, best);
			i = best;
		end
	endfunction

	function automatic void restore_order(input int i);
		if (i > 0 && heap_keys[(i - 1) / 2] > heap_keys[i])
			bubble_up(i);
		else
			bubble_down(i);
	endfunction

	function automatic rsp_t apply_heap_op(input req_t r);
		rsp_t o;
		int   pos;
		o = '0;
		o.status = STAT_OK;
		pos = int'(r.position);
		if (r.kind == KIND_INSERT) begin
			if (key_count >= HEAP_DEPTH) begin
				o.status = STAT_FULL;
			end else begin
				heap_keys[key_count] = r.key;
				key_count++;
				bubble_up(key_count - 1);
			end
		end else if (key_count == 0) begin
			o.status = STAT_EMPTY;
		end else if (r.kind == KIND_EXTRACT) begin
			o.taken_key = heap_keys[0];
			key_count--;
			heap_keys[0] = heap_keys[key_count];
			bubble_down(0);
		end else if (pos >= key_count) begin
			o.status = STAT_BADPOS;
		end else if (r.kind == KIND_REPLACE) begin
			heap_keys[pos] = r.key;
			restore_order(pos);
		end else begin
			o.taken_key = heap_keys[pos];
			key_count--;
			if (pos < key_count) begin
				heap_keys[pos] = heap_keys[key_count];
				restore_order(pos);
			end
		end
		o.min_key = (key_count > 0) ? heap_keys[0] : 32'd0;
		o.count   = 7'(key_count);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count = 0;
			heap_outcomes_q.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (req_valid && !req_stall)
				heap_outcomes_q.push_back(apply_heap_op(req));
			if (rsp_valid && !rsp_stall) begin
				if (heap_outcomes_q.size() == 0) begin
					report_mismatch("unrequested response", rsp.min_key, 32'd0);
				end else begin
					oldest_outcome = heap_outcomes_q.pop_front();
					if (rsp.taken_key !== oldest_outcome.taken_key)
						report_mismatch("taken_key", rsp.taken_key, oldest_outcome.taken_key);
					if (rsp.status !== oldest_outcome.status)
						report_mismatch("status", 32'(rsp.status), 32'(oldest_outcome.status));
					if (rsp.min_key !== oldest_outcome.min_key)
						report_mismatch("min_key", rsp.min_key, oldest_outcome.min_key);
					if (rsp.count !== oldest_outcome.count)
						report_mismatch("count", 32'(rsp.count), 32'(oldest_outcome.count));
				end
			end
			pending <= heap_outcomes_q.size();
		end
	end

endmodule

// ===== tb/min_heap_priority_queue_core_tb.sv =====
// Stimulus and verdict for the min-heap priority queue core.
`timescale 1ns / 1ps

module min_heap_priority_queue_core_tb;
	import mhpq_pkg::*;

	// Run limits. The slowest legal request costs the longest send gap, its own
	// time in the block and the longest receive stall, far below the limit.
	localparam int HEAP_DEPTH  = 64;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 40;
	localparam int CYCLE_LIMIT = 500000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	int   fail_count;
	int   pending;

	// Stimulus-side knobs: idle ceilings per side, and a one-shot long hold
	// that the response process consumes on its next response.
	int   req_gap_max;
	int   rsp_gap_max;
	bit   hold_rsp_long;
	int   shadow_count;   // entry count implied by the requests sent so far
	int   cycle_count;

	min_heap_priority_queue_core #(
		.CAPACITY (HEAP_DEPTH),
		.KEY_WIDTH(32)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	min_heap_priority_queue_core_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Watchdog: a hung handshake or a lost response ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** min_heap_priority_queue_core: FAILED **");
			$finish;
		end
	end

	// Offer one request after a random gap and hold it until accepted.
	// With a zero gap valid just stays high and only the payload moves on.
	task automatic send_request(input req_t r);
		int gap;
		gap = $urandom_range(0, req_gap_max);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	// Track the count so positions can be aimed inside the heap.
	task automatic issue(input logic [1:0] kind, input logic [31:0] key,
			input logic [5:0] position);
		req_t r;
		r.kind     = kind;
		r.key      = key;
		r.position = position;
		if (kind == KIND_INSERT) begin
			if (shadow_count < HEAP_DEPTH)
				shadow_count++;
		end else if (kind == KIND_EXTRACT) begin
			if (shadow_count > 0)
				shadow_count--;
		end else if (kind == KIND_DELETE) begin
			if (shadow_count > 0 && int'(position) < shadow_count)
				shadow_count--;
		end
		send_request(r);
	endtask

	// Stop offering and wait for every outstanding response. The checker's
	// pending count is registered, hence the first clock.
	task automatic drain_responses();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Mix of full-range keys, a narrow range for lots of duplicates, and the
	// extremes.
	function automatic logic [31:0] pick_key();
		logic [31:0] k;
		case ($urandom_range(0, 3))
			0: k = $urandom;
			1: k = 32'($urandom_range(0, 15));
			2: k = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			default: k = 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
		endcase
		return k;
	endfunction

	// Random operations. Positions mostly land inside the heap; about one in
	// ten is drawn over the full field to hit the bad-position path.
	task automatic run_mixed(input int n, input int insert_pct);
		int          roll;
		logic [1:0]  kind;
		logic [5:0]  position;
		repeat (n) begin
			roll = $urandom_range(0, 99);
			if (roll < insert_pct)
				kind = KIND_INSERT;
			else
				case ($urandom_range(0, 2))
					0: kind = KIND_EXTRACT;
					1: kind = KIND_REPLACE;
					default: kind = KIND_DELETE;
				endcase
			if (shadow_count > 0 && $urandom_range(0, 9) != 0)
				position = 6'($urandom_range(0, shadow_count - 1));
			else
				position = 6'($urandom_range(0, 63));
			issue(kind, pick_key(), position);
		end
	endtask

	// Response side: a random stall before each response, or the long hold
	// when one was asked for. The sender keeps going during a hold, so the
	// output register fills and the block stalls its request channel.
	initial begin
		int stall_n;
		forever begin
			stall_n = $urandom_range(0, rsp_gap_max);
			if (hold_rsp_long) begin
				stall_n = HOLD_CYCLES;
				hold_rsp_long = 1'b0;
			end
			if (stall_n > 0) begin
				rsp_stall <= 1'b1;
				repeat (stall_n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
		end
	end

	initial begin
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req           = '0;
		rsp_stall     = 1'b0;
		req_gap_max   = 14;
		rsp_gap_max   = 14;
		hold_rsp_long = 1'b0;
		shadow_count  = 0;
		cycle_count   = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-heap rejects, extremes, equal keys, bad positions,
		// replace sifting both ways, delete of the last slot and of inner ones.
		issue(KIND_EXTRACT, 32'h1234_5678, 6'd0);
		issue(KIND_REPLACE, 32'hFFFF_FFFF, 6'd0);
		issue(KIND_DELETE,  32'h0,         6'd63);
		issue(KIND_INSERT,  32'hFFFF_FFFF, 6'd63);
		issue(KIND_INSERT,  32'h0,         6'd0);
		issue(KIND_INSERT,  32'h0,         6'd0);
		issue(KIND_INSERT,  32'h7,         6'd0);
		issue(KIND_INSERT,  32'h7,         6'd0);
		issue(KIND_INSERT,  32'h3,         6'd0);
		issue(KIND_REPLACE, 32'h1,         6'd6);   // position equals count
		issue(KIND_DELETE,  32'h0,         6'd63);
		issue(KIND_REPLACE, 32'hFFFF_FFFE, 6'd0);   // root sinks
		issue(KIND_REPLACE, 32'h0,         6'd5);   // leaf rises
		issue(KIND_DELETE,  32'h0,         6'd5);   // last slot, nothing moves
		issue(KIND_DELETE,  32'h0,         6'd1);
		issue(KIND_DELETE,  32'h0,         6'd0);
		issue(KIND_EXTRACT, 32'h0,         6'd0);
		issue(KIND_EXTRACT, 32'h0,         6'd0);
		issue(KIND_EXTRACT, 32'h0,         6'd0);
		issue(KIND_EXTRACT, 32'h0,         6'd0);   // empty again
		issue(KIND_INSERT,  32'h0,         6'd0);
		issue(KIND_INSERT,  32'hFFFF_FFFF, 6'd0);
		issue(KIND_REPLACE, 32'h0,         6'd1);   // equal to parent, stays
		issue(KIND_DELETE,  32'h0,         6'd0);
		issue(KIND_DELETE,  32'h0,         6'd0);
		drain_responses();

		// Fill past capacity behind a long response hold, sender flat out.
		req_gap_max   = 0;
		hold_rsp_long = 1'b1;
		repeat (80) issue(KIND_INSERT, pick_key(), 6'($urandom_range(0, 63)));
		drain_responses();

		// Deep heap, both sides idling.
		req_gap_max = 14;
		rsp_gap_max = 14;
		run_mixed(450, 45);
		drain_responses();

		// No idling on either side.
		req_gap_max = 0;
		rsp_gap_max = 0;
		run_mixed(400, 50);
		drain_responses();

		// Second long hold while mixed traffic keeps coming.
		rsp_gap_max   = 14;
		hold_rsp_long = 1'b1;
		run_mixed(300, 55);
		drain_responses();

		// Empty the heap and keep extracting past empty.
		repeat (70) issue(KIND_EXTRACT, pick_key(), 6'($urandom_range(0, 63)));
		drain_responses();

		// Refill with gaps only on the request side.
		req_gap_max = 14;
		rsp_gap_max = 0;
		run_mixed(400, 60);
		drain_responses();

		// Anything arriving now is unrequested and gets flagged.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("** min_heap_priority_queue_core: PASSED **");
		else
			$display("** min_heap_priority_queue_core: FAILED **");
		$finish;
	end

endmodule
